@@ hw/rtl/ecgfc_pkg.sv @@
// Shared constants, types and coefficient tables of the ECG filter chain.
`default_nettype none
package ecgfc_pkg;

    localparam int LOWPASS_TAPS  = 41;
    localparam int HIGHPASS_TAPS = 101;
    localparam int AVERAGE_TAPS  = 20;
    localparam int NOTCH_TAPS    = 5;
    localparam int SAMPLE_BITS   = 12;

    localparam int VAL_W  = 24;
    localparam int COEF_W = 18;
    localparam int ACC_W  = 48;
    localparam int FRAC_W = 8;
    localparam int PROD_W = VAL_W + COEF_W;

    localparam int MAX_TAPS = (HIGHPASS_TAPS > LOWPASS_TAPS) ?
        ((HIGHPASS_TAPS > AVERAGE_TAPS) ? HIGHPASS_TAPS : AVERAGE_TAPS) :
        ((LOWPASS_TAPS > AVERAGE_TAPS) ? LOWPASS_TAPS : AVERAGE_TAPS);
    localparam int K_W   = $clog2(MAX_TAPS + 1);
    localparam int SUM_W = PROD_W + K_W + 1;

    localparam int MEM_DEPTH = LOWPASS_TAPS + HIGHPASS_TAPS + AVERAGE_TAPS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int LP_BASE   = 0;
    localparam int HP_BASE   = LOWPASS_TAPS;
    localparam int AV_BASE   = LOWPASS_TAPS + HIGHPASS_TAPS;

    localparam int AVG_COEF  = (65536 + AVERAGE_TAPS / 2) / AVERAGE_TAPS;
    localparam int MILLI     = 1000;
    localparam int HP_MID    = (HIGHPASS_TAPS - 1) / 2;
    localparam int LP_MID    = (LOWPASS_TAPS - 1) / 2;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_WRITE, ST_ISSUE, ST_DRAIN, ST_FINISH, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_LP, PH_NT, PH_HP, PH_AV, PH_MS
    } t_phase;

    typedef struct packed {
        logic valid;
        logic clear;
    } t_mac_ctl;

    function automatic logic signed [COEF_W-1:0] lp_coef(input logic [K_W-1:0] k);
        logic [K_W-1:0] m;
        logic signed [COEF_W-1:0] c;
        m = (k > K_W'(LP_MID)) ? K_W'(LOWPASS_TAPS - 1) - k : k;
        unique case (m)
            K_W'(1):  c = -18'sd55;
            K_W'(2):  c = 18'sd113;
            K_W'(3):  c = -18'sd152;
            K_W'(4):  c = 18'sd129;
            K_W'(6):  c = -18'sd236;
            K_W'(7):  c = 18'sd506;
            K_W'(8):  c = -18'sd658;
            K_W'(9):  c = 18'sd522;
            K_W'(11): c = -18'sd834;
            K_W'(12): c = 18'sd1692;
            K_W'(13): c = -18'sd2123;
            K_W'(14): c = 18'sd1657;
            K_W'(16): c = -18'sd2797;
            K_W'(17): c = 18'sd6284;
            K_W'(18): c = -18'sd9700;
            K_W'(19): c = 18'sd12197;
            K_W'(20): c = 18'sd52450;
            default:  c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] hp_coef(input logic [K_W-1:0] k);
        logic [K_W-1:0] m;
        logic signed [COEF_W-1:0] c;
        m = (k > K_W'(HP_MID)) ? K_W'(HIGHPASS_TAPS - 1) - k : k;
        unique case (m)
            K_W'(0), K_W'(1):   c = -18'sd10;
            K_W'(2), K_W'(3):   c = -18'sd11;
            K_W'(4):  c = -18'sd12;
            K_W'(5):  c = -18'sd13;
            K_W'(6):  c = -18'sd15;
            K_W'(7):  c = -18'sd16;
            K_W'(8):  c = -18'sd18;
            K_W'(9):  c = -18'sd20;
            K_W'(10): c = -18'sd22;
            K_W'(11): c = -18'sd24;
            K_W'(12): c = -18'sd27;
            K_W'(13): c = -18'sd29;
            K_W'(14): c = -18'sd32;
            K_W'(15): c = -18'sd35;
            K_W'(16): c = -18'sd38;
            K_W'(17): c = -18'sd41;
            K_W'(18): c = -18'sd45;
            K_W'(19): c = -18'sd48;
            K_W'(20): c = -18'sd52;
            K_W'(21): c = -18'sd55;
            K_W'(22): c = -18'sd59;
            K_W'(23): c = -18'sd63;
            K_W'(24): c = -18'sd67;
            K_W'(25): c = -18'sd70;
            K_W'(26): c = -18'sd74;
            K_W'(27): c = -18'sd78;
            K_W'(28): c = -18'sd82;
            K_W'(29): c = -18'sd86;
            K_W'(30): c = -18'sd89;
            K_W'(31): c = -18'sd93;
            K_W'(32): c = -18'sd96;
            K_W'(33): c = -18'sd100;
            K_W'(34): c = -18'sd103;
            K_W'(35): c = -18'sd106;
            K_W'(36): c = -18'sd109;
            K_W'(37): c = -18'sd112;
            K_W'(38): c = -18'sd115;
            K_W'(39): c = -18'sd117;
            K_W'(40): c = -18'sd119;
            K_W'(41): c = -18'sd122;
            K_W'(42): c = -18'sd124;
            K_W'(43): c = -18'sd125;
            K_W'(44): c = -18'sd127;
            K_W'(45): c = -18'sd128;
            K_W'(46): c = -18'sd129;
            K_W'(47): c = -18'sd130;
            K_W'(48), K_W'(49): c = -18'sd131;
            K_W'(50): c = 18'sd65415;
            default:  c = '0;
        endcase
        return c;
    endfunction

    function automatic logic signed [COEF_W-1:0] notch_coef(input logic [K_W-1:0] k);
        logic signed [COEF_W-1:0] c;
        unique case (k)
            K_W'(0): c = 18'sd65025;
            K_W'(1): c = -18'sd105213;
            K_W'(2): c = 18'sd65025;
            K_W'(3): c = 18'sd105304;
            K_W'(4): c = -18'sd64627;
            default: c = '0;
        endcase
        return c;
    endfunction

    // clamp to 48 bits, round half up, drop 16 bits, clamp to 24 bits
    function automatic logic signed [VAL_W-1:0] stage_round(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [ACC_W:0]    s;
        logic signed [ACC_W-16:0] q;
        logic signed [VAL_W-1:0]  r;
        if ((&acc[SUM_W-1:ACC_W-1]) || !(|acc[SUM_W-1:ACC_W-1]))
            s = (ACC_W+1)'(acc);
        else if (acc[SUM_W-1])
            s = {2'b11, {(ACC_W-1){1'b0}}};
        else
            s = {2'b00, {(ACC_W-1){1'b1}}};
        s = s + (ACC_W+1)'(32768);
        q = s[ACC_W:16];
        if ((&q[ACC_W-16:VAL_W-1]) || !(|q[ACC_W-16:VAL_W-1]))
            r = q[VAL_W-1:0];
        else
            r = q[ACC_W-16] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return r;
    endfunction

    // divide by 256 toward zero, clamp to 24 bits
    function automatic logic signed [VAL_W-1:0] milli_round(
        input logic signed [SUM_W-1:0] acc
    );
        logic signed [SUM_W-1:0] t;
        logic signed [VAL_W-1:0] r;
        t = acc >>> FRAC_W;
        if (acc[SUM_W-1] && (|acc[FRAC_W-1:0]))
            t = t + SUM_W'(1);
        if ((&t[SUM_W-1:VAL_W-1]) || !(|t[SUM_W-1:VAL_W-1]))
            r = t[VAL_W-1:0];
        else
            r = t[SUM_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ecgfc_in_if.sv @@
// Sample input channel.
`default_nettype none
interface ecgfc_in_if ();
    import ecgfc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;
    modport source (output valid, output raw_sample, input ready);
    modport sink   (input valid, input raw_sample, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ecgfc_out_if.sv @@
// Result output channel.
`default_nettype none
interface ecgfc_out_if ();
    import ecgfc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] filtered_milli;
    logic [SAMPLE_BITS-1:0]  raw_echo;
    modport source (output valid, output filtered_milli, output raw_echo, input ready);
    modport sink   (input valid, input filtered_milli, input raw_echo, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/ecgfc_mac.sv @@
// Shared multiply-accumulate unit: registered product, then wide accumulator.
`default_nettype none
module ecgfc_mac (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  ecgfc_pkg::t_mac_ctl             i_ctl,
    input  wire signed [ecgfc_pkg::VAL_W-1:0]  i_a,
    input  wire signed [ecgfc_pkg::COEF_W-1:0] i_b,
    output logic signed [ecgfc_pkg::SUM_W-1:0] o_acc
);
    import ecgfc_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_pv;
    logic signed [SUM_W-1:0]  r_acc;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_pv <= i_ctl.valid;
            if (i_ctl.clear) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc <= r_acc + SUM_W'(r_prod);
            end
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

@@ hw/rtl/ecgfc_delay_mem.sv @@
// Delay-line memory holding all three FIR histories, one write and one read port.
`default_nettype none
module ecgfc_delay_mem (
    input  wire                               i_clk,
    input  wire                               i_we,
    input  wire [ecgfc_pkg::MEM_AW-1:0]       i_waddr,
    input  wire signed [ecgfc_pkg::VAL_W-1:0] i_wdata,
    input  wire [ecgfc_pkg::MEM_AW-1:0]       i_raddr,
    output logic signed [ecgfc_pkg::VAL_W-1:0] o_rdata
);
    import ecgfc_pkg::*;

    logic signed [VAL_W-1:0] r_mem [MEM_DEPTH];
    logic signed [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ hw/rtl/ecgfc_seq.sv @@
// Sequencer: steps the shared MAC through each filter stage and owns the channels.
`default_nettype none
module ecgfc_seq (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    ecgfc_in_if.sink                           i_in,
    ecgfc_out_if.source                        o_out,
    output logic                               o_we,
    output logic [ecgfc_pkg::MEM_AW-1:0]       o_waddr,
    output logic signed [ecgfc_pkg::VAL_W-1:0] o_wdata,
    output logic [ecgfc_pkg::MEM_AW-1:0]       o_raddr,
    input  wire signed [ecgfc_pkg::VAL_W-1:0]  i_rdata,
    output ecgfc_pkg::t_mac_ctl                o_mac_ctl,
    output logic signed [ecgfc_pkg::VAL_W-1:0] o_mac_a,
    output logic signed [ecgfc_pkg::COEF_W-1:0] o_mac_b,
    input  wire signed [ecgfc_pkg::SUM_W-1:0]  i_acc
);
    import ecgfc_pkg::*;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [MEM_AW-1:0]       r_clr, n_clr;
    logic [MEM_AW-1:0]       r_lp_ptr, n_lp_ptr;
    logic [MEM_AW-1:0]       r_hp_ptr, n_hp_ptr;
    logic [MEM_AW-1:0]       r_av_ptr, n_av_ptr;
    logic [MEM_AW-1:0]       r_addr, n_addr;
    logic [K_W-1:0]          r_k, n_k;
    logic [1:0]              r_drain, n_drain;
    logic signed [VAL_W-1:0] r_stage, n_stage;
    logic signed [VAL_W-1:0] r_nh [4];
    logic signed [VAL_W-1:0] n_nh [4];
    logic [SAMPLE_BITS-1:0]  r_raw, n_raw;
    logic                    r_out_valid, n_out_valid;
    logic signed [VAL_W-1:0] r_milli, n_milli;
    logic [SAMPLE_BITS-1:0]  r_echo, n_echo;

    logic                     r_v1;
    logic                     r_opsel;
    logic signed [VAL_W-1:0]  r_regop;
    logic signed [COEF_W-1:0] r_coef;

    logic                     issue;
    logic                     opsel;
    logic signed [VAL_W-1:0]  regop;
    logic signed [COEF_W-1:0] coef;
    logic [K_W-1:0]           last_k;
    logic [MEM_AW-1:0]        base;
    logic [MEM_AW-1:0]        len;
    logic [MEM_AW-1:0]        ptr;
    logic signed [VAL_W-1:0]  fin;

    // per-phase geometry and operand selection
    always_comb begin
        opsel  = 1'b0;
        regop  = r_stage;
        coef   = '0;
        last_k = '0;
        base   = MEM_AW'(LP_BASE);
        len    = MEM_AW'(LOWPASS_TAPS);
        ptr    = r_lp_ptr;
        unique case (r_phase)
            PH_LP: begin
                coef   = lp_coef(r_k);
                last_k = K_W'(LOWPASS_TAPS - 1);
            end
            PH_NT: begin
                opsel  = 1'b1;
                coef   = notch_coef(r_k);
                last_k = K_W'(NOTCH_TAPS - 1);
                if (r_k != '0) begin
                    regop = r_nh[2'(r_k - K_W'(1))];
                end
            end
            PH_HP: begin
                coef   = hp_coef(r_k);
                last_k = K_W'(HIGHPASS_TAPS - 1);
                base   = MEM_AW'(HP_BASE);
                len    = MEM_AW'(HIGHPASS_TAPS);
                ptr    = r_hp_ptr;
            end
            PH_AV: begin
                coef   = COEF_W'(AVG_COEF);
                last_k = K_W'(AVERAGE_TAPS - 1);
                base   = MEM_AW'(AV_BASE);
                len    = MEM_AW'(AVERAGE_TAPS);
                ptr    = r_av_ptr;
            end
            PH_MS: begin
                opsel = 1'b1;
                coef  = COEF_W'(MILLI);
            end
            default: begin
                coef = '0;
            end
        endcase
    end

    assign fin   = stage_round(i_acc);
    assign issue = (r_state == ST_ISSUE);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clr       = r_clr;
        n_lp_ptr    = r_lp_ptr;
        n_hp_ptr    = r_hp_ptr;
        n_av_ptr    = r_av_ptr;
        n_addr      = r_addr;
        n_k         = r_k;
        n_drain     = r_drain;
        n_stage     = r_stage;
        n_nh        = r_nh;
        n_raw       = r_raw;
        n_out_valid = r_out_valid;
        n_milli     = r_milli;
        n_echo      = r_echo;
        o_we        = 1'b0;
        o_waddr     = base + ptr;
        o_wdata     = r_stage;
        i_in.ready  = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                o_wdata = '0;
                n_clr   = r_clr + MEM_AW'(1);
                if (r_clr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_raw   = i_in.raw_sample;
                    n_stage = VAL_W'({i_in.raw_sample, {FRAC_W{1'b0}}});
                    n_phase = PH_LP;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_we    = 1'b1;
                n_addr  = ptr;
                n_k     = '0;
                n_state = ST_ISSUE;
            end
            ST_ISSUE: begin
                n_addr = (r_addr == '0) ? len - MEM_AW'(1) : r_addr - MEM_AW'(1);
                n_k    = r_k + K_W'(1);
                if (r_k == last_k) begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                n_k = '0;
                unique case (r_phase)
                    PH_LP: begin
                        n_stage  = fin;
                        n_lp_ptr = (r_lp_ptr == MEM_AW'(LOWPASS_TAPS - 1)) ?
                                   '0 : r_lp_ptr + MEM_AW'(1);
                        n_phase  = PH_NT;
                        n_state  = ST_ISSUE;
                    end
                    PH_NT: begin
                        n_nh[1] = r_nh[0];
                        n_nh[0] = r_stage;
                        n_nh[3] = r_nh[2];
                        n_nh[2] = fin;
                        n_stage = fin;
                        n_phase = PH_HP;
                        n_state = ST_WRITE;
                    end
                    PH_HP: begin
                        n_stage  = fin;
                        n_hp_ptr = (r_hp_ptr == MEM_AW'(HIGHPASS_TAPS - 1)) ?
                                   '0 : r_hp_ptr + MEM_AW'(1);
                        n_phase  = PH_AV;
                        n_state  = ST_WRITE;
                    end
                    PH_AV: begin
                        n_stage  = fin;
                        n_av_ptr = (r_av_ptr == MEM_AW'(AVERAGE_TAPS - 1)) ?
                                   '0 : r_av_ptr + MEM_AW'(1);
                        n_phase  = PH_MS;
                        n_state  = ST_ISSUE;
                    end
                    PH_MS: begin
                        n_stage = milli_round(i_acc);
                        n_state = ST_OUT;
                    end
                    default: begin
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_milli     = r_stage;
                    n_echo      = r_raw;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_phase     <= PH_LP;
            r_clr       <= '0;
            r_lp_ptr    <= '0;
            r_hp_ptr    <= '0;
            r_av_ptr    <= '0;
            r_k         <= '0;
            r_drain     <= '0;
            r_nh        <= '{default: '0};
            r_out_valid <= 1'b0;
            r_v1        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clr       <= n_clr;
            r_lp_ptr    <= n_lp_ptr;
            r_hp_ptr    <= n_hp_ptr;
            r_av_ptr    <= n_av_ptr;
            r_k         <= n_k;
            r_drain     <= n_drain;
            r_nh        <= n_nh;
            r_out_valid <= n_out_valid;
            r_v1        <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr  <= n_addr;
        r_stage <= n_stage;
        r_raw   <= n_raw;
        r_milli <= n_milli;
        r_echo  <= n_echo;
        r_opsel <= opsel;
        r_regop <= regop;
        r_coef  <= coef;
    end

    assign o_raddr         = base + r_addr;
    assign o_mac_ctl.valid = r_v1;
    assign o_mac_ctl.clear = (r_state == ST_FINISH) || (r_state == ST_IDLE);
    assign o_mac_a         = r_opsel ? r_regop : i_rdata;
    assign o_mac_b         = r_coef;

    assign o_out.valid          = r_out_valid;
    assign o_out.filtered_milli = r_milli;
    assign o_out.raw_echo       = r_echo;
endmodule
`default_nettype wire

@@ hw/rtl/ecg_filter_chain_top.sv @@
// ECG filter chain top level: sequencer, shared MAC and delay-line memory.
//
// Usage: one 12-bit converter sample enters per beat on i_in (valid/ready);
// one beat leaves on o_out carrying the filtered value times 1000
// (signed 24 bits, saturated) and the raw sample echoed.
// Chain: 41-tap FIR low-pass, notch biquad, 101-tap FIR high-pass,
// 20-tap moving average, all on one shared multiply-accumulate unit.
// Sequence: each pass issues one MAC operation per cycle, then drains
// the MAC pipeline and rounds the stage result; each FIR pass is
// preceded by a delay-line write, and the result is loaded into the
// output register at the end.
// A new sample is accepted only after the previous one has been worked
// through; i_in.ready is high only while the sequencer is idle.
// Reset: synchronous, active low. After reset all 162 delay-memory words
// are swept to zero, and no sample is accepted during the sweep.
// Stall: the result waits in an output register; the next sample is
// accepted while it waits, but its result is held until o_out is free.
`default_nettype none
module ecg_filter_chain_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ecgfc_in_if.sink     i_in,
    ecgfc_out_if.source  o_out
);
    import ecgfc_pkg::*;

    logic                     we;
    logic [MEM_AW-1:0]        waddr;
    logic signed [VAL_W-1:0]  wdata;
    logic [MEM_AW-1:0]        raddr;
    logic signed [VAL_W-1:0]  rdata;
    t_mac_ctl                 mac_ctl;
    logic signed [VAL_W-1:0]  mac_a;
    logic signed [COEF_W-1:0] mac_b;
    logic signed [SUM_W-1:0]  acc;

    ecgfc_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_out     (o_out),
        .o_we      (we),
        .o_waddr   (waddr),
        .o_wdata   (wdata),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_mac_ctl (mac_ctl),
        .o_mac_a   (mac_a),
        .o_mac_b   (mac_b),
        .i_acc     (acc)
    );

    ecgfc_delay_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ecgfc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );
endmodule
`default_nettype wire

@@ tb/ecgfc_tb_pkg.sv @@
// Scoreboard class and fixed-point predictor of the ECG filter chain.
`timescale 1ns / 100ps
package ecgfc_tb_pkg;
    import ecgfc_pkg::*;

    class ecg_scoreboard;
        int lp_line [LOWPASS_TAPS];
        int hp_line [HIGHPASS_TAPS];
        int av_line [AVERAGE_TAPS];
        int nt_x1, nt_x2, nt_y1, nt_y2;
        int lp_taps [LOWPASS_TAPS];
        int hp_taps [HIGHPASS_TAPS];
        int nt_taps [NOTCH_TAPS];
        logic [VAL_W-1:0]       milli_q [$];
        logic [SAMPLE_BITS-1:0] echo_q [$];
        int mismatches;

        function new();
            int m;
            // symmetric tables, coefficients by half-index
            int lp_half [21] = '{0, -55, 113, -152, 129, 0, -236, 506, -658, 522,
                0, -834, 1692, -2123, 1657, 0, -2797, 6284, -9700, 12197, 52450};
            int hp_half [51] = '{-10, -10, -11, -11, -12, -13, -15, -16, -18, -20,
                -22, -24, -27, -29, -32, -35, -38, -41, -45, -48,
                -52, -55, -59, -63, -67, -70, -74, -78, -82, -86,
                -89, -93, -96, -100, -103, -106, -109, -112, -115, -117,
                -119, -122, -124, -125, -127, -128, -129, -130, -131, -131, 65415};
            for (int k = 0; k < LOWPASS_TAPS; k++) begin
                m = (k > 20) ? 40 - k : k;
                lp_taps[k] = lp_half[m];
                lp_line[k] = 0;
            end
            for (int k = 0; k < HIGHPASS_TAPS; k++) begin
                m = (k > 50) ? 100 - k : k;
                hp_taps[k] = hp_half[m];
                hp_line[k] = 0;
            end
            foreach (av_line[k]) av_line[k] = 0;
            nt_taps = '{65025, -105213, 65025, 105304, -64627};
            nt_x1 = 0; nt_x2 = 0; nt_y1 = 0; nt_y2 = 0;
            mismatches = 0;
        endfunction

        function automatic int clamp24(longint v);
            if (v > 64'sd8388607) return 8388607;
            if (v < -64'sd8388608) return -8388608;
            return int'(v);
        endfunction

        function automatic int requantise(longint acc);
            longint v, q;
            if (acc > 64'sd140737488355327) acc = 64'sd140737488355327;
            if (acc < -64'sd140737488355328) acc = -64'sd140737488355328;
            v = acc + 32768;
            q = v >>> 16;
            return clamp24(q);
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] raw);
            longint acc, milli;
            int lp, nt, hp, av;
            for (int k = LOWPASS_TAPS - 1; k > 0; k--) lp_line[k] = lp_line[k-1];
            lp_line[0] = int'(raw) << FRAC_W;
            acc = 0;
            foreach (lp_line[k]) acc += longint'(lp_line[k]) * lp_taps[k];
            lp = requantise(acc);
            acc = longint'(lp) * nt_taps[0] + longint'(nt_x1) * nt_taps[1]
                + longint'(nt_x2) * nt_taps[2] + longint'(nt_y1) * nt_taps[3]
                + longint'(nt_y2) * nt_taps[4];
            nt = requantise(acc);
            nt_x2 = nt_x1; nt_x1 = lp; nt_y2 = nt_y1; nt_y1 = nt;
            for (int k = HIGHPASS_TAPS - 1; k > 0; k--) hp_line[k] = hp_line[k-1];
            hp_line[0] = nt;
            acc = 0;
            foreach (hp_line[k]) acc += longint'(hp_line[k]) * hp_taps[k];
            hp = requantise(acc);
            for (int k = AVERAGE_TAPS - 1; k > 0; k--) av_line[k] = av_line[k-1];
            av_line[0] = hp;
            acc = 0;
            foreach (av_line[k]) acc += av_line[k];
            av = requantise(acc * AVG_COEF);
            milli = (longint'(av) * MILLI) / 256;
            milli_q.push_back(VAL_W'(clamp24(milli)));
            echo_q.push_back(raw);
        endfunction

        function void check_result(logic [VAL_W-1:0] milli, logic [SAMPLE_BITS-1:0] echo);
            logic [VAL_W-1:0] exp_milli;
            logic [SAMPLE_BITS-1:0] exp_echo;
            if (milli_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: milli=%0d echo=%0d", $signed(milli), echo);
                return;
            end
            exp_milli = milli_q.pop_front();
            exp_echo = echo_q.pop_front();
            if (milli !== exp_milli || echo !== exp_echo) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: milli exp %0d got %0d, echo exp %0d got %0d",
                        $signed(exp_milli), $signed(milli), exp_echo, echo);
            end
        endfunction

        function int pending();
            return milli_q.size();
        endfunction
    endclass
endpackage

@@ tb/ecg_filter_chain_top_tb.sv @@
// Self-checking testbench of the ECG filter chain top level.
`timescale 1ns / 100ps
module ecg_filter_chain_top_tb;
    import ecgfc_pkg::*;
    import ecgfc_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   holdoff_cycles;
    ecg_scoreboard board;

    ecgfc_in_if  in_ch ();
    ecgfc_out_if out_ch ();

    ecg_filter_chain_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.raw_sample = '0;
        out_ch.ready = 1'b0;
    end

    // time limit about ten times the expected run of 1150 samples plus stalls
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2_500_000) begin
            $display("ecg_filter_chain_top verification failed");
            $finish;
        end
    end

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.raw_sample <= raw;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_sample(raw);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
    endtask

    // receiver side
    always @(negedge i_clk) begin
        if (holdoff_cycles > 0) begin
            out_ch.ready <= 1'b0;
            holdoff_cycles <= holdoff_cycles - 1;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.filtered_milli, out_ch.raw_echo);
    end

    initial begin
        logic [SAMPLE_BITS-1:0] raw;
        board = new();
        cycle_count = 0;
        holdoff_cycles = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, step, alternating, mid-scale
        send_sample('0);
        send_sample('1);
        repeat (6) send_sample(12'hFFF);
        send_sample(12'h000);
        for (int i = 0; i < 8; i++) send_sample(i[0] ? 12'hFFF : 12'h000);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'h800);
        send_sample(12'h7FF);
        send_sample(12'h001);
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 25 : (ph == 1) ? 75 : 0;
            snk_idle_pct = (ph == 0) ? 75 : (ph == 1) ? 25 : 0;
            if (ph == 2) begin
                // long receiver hold-off while samples keep coming
                holdoff_cycles <= 1500;
            end
            for (int n = 0; n < 375; n++) begin
                case ($urandom_range(3))
                    0: raw = SAMPLE_BITS'($urandom_range(4095));
                    1: raw = $urandom_range(1) ? 12'hFFF : 12'h000;
                    2: raw = SAMPLE_BITS'(2048 + $urandom_range(200) - 100);
                    default: raw = (n % 40 < 20) ?
                                   SAMPLE_BITS'(12'hE00 + $urandom_range(255)) :
                                   SAMPLE_BITS'($urandom_range(255));
                endcase
                send_sample(raw);
                if (n == 180) wait_drained();
            end
        end
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ecg_filter_chain_top verification clean");
        else
            $display("ecg_filter_chain_top verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
hw/rtl/ecgfc_pkg.sv
hw/rtl/ecgfc_in_if.sv
hw/rtl/ecgfc_out_if.sv
hw/rtl/ecgfc_mac.sv
hw/rtl/ecgfc_delay_mem.sv
hw/rtl/ecgfc_seq.sv
hw/rtl/ecg_filter_chain_top.sv
tb/ecgfc_tb_pkg.sv
tb/ecg_filter_chain_top_tb.sv
